@@ src/kvc_pkg.sv @@
// ----------------------------------------------------------------------------
// kvc_pkg
// Shared types and constants of the key-value cache with LRU/LFU and TTL.
// ----------------------------------------------------------------------------
`default_nettype none
package kvc_pkg;

   localparam int CAPACITY   = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int TIME_BITS  = 32;
   localparam int USES_BITS  = 32;
   localparam int TOTAL_BITS = 32;
   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int CFG_BITS   = 5;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [2:0] OP_PUT    = 3'd0;
   localparam logic [2:0] OP_GET    = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_EXISTS = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_ENTRIES = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_POLICY      = 1'd1;

   localparam logic POLICY_LRU = 1'b0;

   typedef struct packed {
      logic [2:0]            opcode;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value_in;
      logic [TIME_BITS-1:0]  ttl;
      logic [TIME_BITS-1:0]  now_ms;
   } req_type;

   typedef struct packed {
      logic                  status;
      logic [VALUE_BITS-1:0] value_out;
      logic                  present;
      logic [TOTAL_BITS-1:0] hit_total;
      logic [TOTAL_BITS-1:0] miss_total;
      logic [TOTAL_BITS-1:0] eviction_total;
      logic [CNT_BITS-1:0]   occupancy;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic [TIME_BITS-1:0]  stamp;
      logic [TIME_BITS-1:0]  life;
      logic [USES_BITS-1:0]  uses;
      logic [IDX_BITS-1:0]   rank;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef enum logic [1:0] {
      RANK_NONE,
      RANK_INC_BELOW,
      RANK_DEC_ABOVE,
      RANK_INC_ALL
   } rank_op_type;

endpackage
`default_nettype wire

@@ src/kvc_ram.sv @@
// ----------------------------------------------------------------------------
// kvc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module kvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ src/kv_cache_lru_lfu_ttl.sv @@
// ----------------------------------------------------------------------------
// kv_cache_lru_lfu_ttl
// Fully associative key-value cache with LRU/LFU eviction and per-entry TTL.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; its single result
// appears on rsp_data for exactly one cycle with rsp_strobe high and must be
// captured then. Entries live in one RAM that a sequencer walks one slot a
// cycle: every lookup is a scan of all CAPACITY slots, and an operation that
// changes ranks or entry contents adds a read-modify-write pass over all
// slots. A get miss, an exists and a failed delete need only the scan; a
// get hit, a delete and a put also take the pass. A put of a new key to a
// full store adds a pass and a rescan per evicted entry: one entry
// normally, more when max_entries was lowered. Clear and unused opcodes keep
// busy high for 1 cycle. The result strobe follows in the cycle busy drops.
`default_nettype none
module kv_cache_lru_lfu_ttl (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output      logic                               busy,
   input  wire kvc_pkg::req_type                   req_data,
   output      logic                               rsp_strobe,
   output      kvc_pkg::rsp_type                   rsp_data,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [kvc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [kvc_pkg::CFG_BITS-1:0]       csr_data
);

   localparam int IB = kvc_pkg::IDX_BITS;
   localparam int CB = kvc_pkg::CNT_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_PASS,
      S_RESP
   } state_type;

   state_type               state_ff, state_in;
   kvc_pkg::req_type        req_ff, req_in;
   logic [CB-1:0]           cnt_ff, cnt_in;
   logic                    pend_ff, pend_in;
   logic [IB-1:0]           pidx_ff, pidx_in;
   logic [kvc_pkg::CAPACITY-1:0] valid_ff, valid_in;
   logic [CB-1:0]           live_ff, live_in;
   logic [kvc_pkg::TOTAL_BITS-1:0] hits_ff, hits_in, miss_ff, miss_in, evict_ff, evict_in;
   logic                    found_ff, found_in;
   logic [IB-1:0]           fslot_ff, fslot_in;
   kvc_pkg::entry_type      fent_ff, fent_in;
   logic                    vic_ff, vic_in;
   logic [IB-1:0]           vslot_ff, vslot_in;
   kvc_pkg::entry_type      vent_ff, vent_in;
   logic                    free_ff, free_in;
   logic [IB-1:0]           fidx_ff, fidx_in;
   kvc_pkg::rank_op_type    rop_ff, rop_in;
   logic [IB-1:0]           rref_ff, rref_in;
   logic                    twr_ff, twr_in;
   logic [IB-1:0]           tgt_ff, tgt_in;
   kvc_pkg::entry_type      tent_ff, tent_in;
   logic                    again_ff, again_in;
   logic                    status_ff, status_in;
   logic [kvc_pkg::VALUE_BITS-1:0] vout_ff, vout_in;
   logic                    present_ff, present_in;
   logic [kvc_pkg::CFG_BITS-1:0] max_ff, max_in;
   logic                    policy_ff, policy_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   kvc_pkg::rsp_type        rsp_ff, rsp_in;

   logic                    ram_we;
   logic [IB-1:0]           ram_waddr;
   kvc_pkg::entry_type      ram_wdata;
   logic [kvc_pkg::ENTRY_BITS-1:0] ram_rdata;
   kvc_pkg::entry_type      rd_ent;
   kvc_pkg::entry_type      ent;
   logic                    walk_done;
   logic                    better;
   logic [CB-1:0]           cap;
   logic                    expired;
   logic                    live_hit;

   kvc_ram #(
      .WIDTH(kvc_pkg::ENTRY_BITS),
      .DEPTH(kvc_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cnt_ff[IB-1:0]),
      .rd_data (ram_rdata)
   );

   assign rd_ent     = kvc_pkg::entry_type'(ram_rdata);
   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign walk_done  = (cnt_ff == CB'(kvc_pkg::CAPACITY)) && !pend_ff;

   always_comb begin
      if (max_ff == '0) begin
         cap = CB'(1);
      end else if (CB'(max_ff) > CB'(kvc_pkg::CAPACITY)) begin
         cap = CB'(kvc_pkg::CAPACITY);
      end else begin
         cap = CB'(max_ff);
      end
   end

   assign expired  = (fent_ff.life != '0) && ((req_ff.now_ms - fent_ff.stamp) > fent_ff.life);
   assign live_hit = found_ff && !expired;

   always_comb begin
      if (policy_ff == kvc_pkg::POLICY_LRU) begin
         better = rd_ent.rank > vent_ff.rank;
      end else begin
         better = (rd_ent.uses < vent_ff.uses) ||
                  ((rd_ent.uses == vent_ff.uses) && (rd_ent.rank < vent_ff.rank));
      end
   end

   // write-back path of the rank pass
   always_comb begin
      ram_we    = (state_ff == S_PASS) && pend_ff;
      ram_waddr = pidx_ff;
      ram_wdata = rd_ent;
      if (twr_ff && (pidx_ff == tgt_ff)) begin
         ram_wdata = tent_ff;
      end else if (valid_ff[pidx_ff]) begin
         case (rop_ff)
            kvc_pkg::RANK_INC_BELOW: begin
               if (rd_ent.rank < rref_ff) ram_wdata.rank = rd_ent.rank + 1'b1;
            end
            kvc_pkg::RANK_DEC_ABOVE: begin
               if (rd_ent.rank > rref_ff) ram_wdata.rank = rd_ent.rank - 1'b1;
            end
            kvc_pkg::RANK_INC_ALL: ram_wdata.rank = rd_ent.rank + 1'b1;
            default: ram_wdata = rd_ent;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;   req_in = req_ff;     cnt_in = cnt_ff;
      pend_in = 1'b0;        pidx_in = pidx_ff;   valid_in = valid_ff;
      live_in = live_ff;     hits_in = hits_ff;   miss_in = miss_ff;
      evict_in = evict_ff;   found_in = found_ff; fslot_in = fslot_ff;
      fent_in = fent_ff;     vic_in = vic_ff;     vslot_in = vslot_ff;
      vent_in = vent_ff;     free_in = free_ff;   fidx_in = fidx_ff;
      rop_in = rop_ff;       rref_in = rref_ff;   twr_in = twr_ff;
      tgt_in = tgt_ff;       tent_in = tent_ff;   again_in = again_ff;
      status_in = status_ff; vout_in = vout_ff;   present_in = present_ff;
      max_in = max_ff;       policy_in = policy_ff;
      rsp_strobe_in = 1'b0;  rsp_in = rsp_ff;
      ent = fent_ff;

      if (csr_valid) begin
         case (csr_index)
            kvc_pkg::CSR_MAX_ENTRIES: max_in = csr_data;
            kvc_pkg::CSR_POLICY:      policy_in = csr_data[0];
            default: ;
         endcase
      end

      // issue reads while walking the store
      if ((state_ff == S_SCAN || state_ff == S_PASS) &&
          (cnt_ff < CB'(kvc_pkg::CAPACITY))) begin
         pend_in = 1'b1;
         pidx_in = cnt_ff[IB-1:0];
         cnt_in  = cnt_ff + 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               status_in = 1'b0; vout_in = '0; present_in = 1'b0;
               cnt_in = '0; found_in = 1'b0; vic_in = 1'b0; free_in = 1'b0;
               if (req_data.opcode == kvc_pkg::OP_CLEAR) begin
                  valid_in = '0;
                  live_in  = '0;
                  state_in = S_RESP;
               end else if (req_data.opcode > kvc_pkg::OP_CLEAR) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (pend_ff && valid_ff[pidx_ff]) begin
               if (!found_ff && rd_ent.key == req_ff.key) begin
                  found_in = 1'b1; fslot_in = pidx_ff; fent_in = rd_ent;
               end
               if (!vic_ff || better) begin
                  vic_in = 1'b1; vslot_in = pidx_ff; vent_in = rd_ent;
               end
            end else if (pend_ff && !free_ff) begin
               free_in = 1'b1; fidx_in = pidx_ff;
            end
            if (walk_done) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_RESP;
            again_in = 1'b0;
            cnt_in   = '0;
            twr_in   = 1'b0;
            rop_in   = kvc_pkg::RANK_NONE;
            rref_in  = fent_ff.rank;
            tgt_in   = fslot_ff;
            case (req_ff.opcode)
               kvc_pkg::OP_GET: begin
                  if (live_hit) begin
                     hits_in = hits_ff + 1'b1;
                     vout_in = fent_ff.value;
                     ent.uses = fent_ff.uses + 1'b1;
                     if (policy_ff == kvc_pkg::POLICY_LRU) begin
                        ent.rank = '0;
                        rop_in = kvc_pkg::RANK_INC_BELOW;
                     end
                     tent_in = ent; twr_in = 1'b1; state_in = S_PASS;
                  end else begin
                     miss_in = miss_ff + 1'b1;
                     status_in = 1'b1;
                  end
               end
               kvc_pkg::OP_DELETE: begin
                  if (live_hit) begin
                     valid_in[fslot_ff] = 1'b0;
                     live_in = live_ff - 1'b1;
                     rop_in = kvc_pkg::RANK_DEC_ABOVE;
                     state_in = S_PASS;
                  end else begin
                     status_in = 1'b1;
                  end
               end
               kvc_pkg::OP_EXISTS: begin
                  present_in = live_hit;
                  status_in  = !live_hit;
               end
               kvc_pkg::OP_PUT: begin
                  if (found_ff) begin
                     ent.value = req_ff.value_in;
                     ent.stamp = req_ff.now_ms;
                     ent.life  = req_ff.ttl;
                     if (expired) ent.uses = '0;
                     if (expired || policy_ff == kvc_pkg::POLICY_LRU) begin
                        ent.rank = '0;
                        rop_in = kvc_pkg::RANK_INC_BELOW;
                     end
                     tent_in = ent; twr_in = 1'b1; state_in = S_PASS;
                  end else if (live_ff >= cap && live_ff != '0) begin
                     // drop the victim, then rescan for the next one
                     valid_in[vslot_ff] = 1'b0;
                     live_in  = live_ff - 1'b1;
                     evict_in = evict_ff + 1'b1;
                     rop_in   = kvc_pkg::RANK_DEC_ABOVE;
                     rref_in  = vent_ff.rank;
                     again_in = 1'b1;
                     state_in = S_PASS;
                  end else if (free_ff) begin
                     ent.key   = req_ff.key;
                     ent.value = req_ff.value_in;
                     ent.stamp = req_ff.now_ms;
                     ent.life  = req_ff.ttl;
                     ent.uses  = '0;
                     ent.rank  = '0;
                     tent_in = ent; twr_in = 1'b1; tgt_in = fidx_ff;
                     rop_in = kvc_pkg::RANK_INC_ALL;
                     valid_in[fidx_ff] = 1'b1;
                     live_in = live_ff + 1'b1;
                     state_in = S_PASS;
                  end
               end
               default: ;
            endcase
         end
         S_PASS: begin
            if (walk_done) begin
               if (again_ff) begin
                  cnt_in = '0; found_in = 1'b0; vic_in = 1'b0; free_in = 1'b0;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_RESP: begin
            rsp_strobe_in = 1'b1;
            rsp_in.status = status_ff;
            rsp_in.value_out = vout_ff;
            rsp_in.present = present_ff;
            rsp_in.hit_total = hits_ff;
            rsp_in.miss_total = miss_ff;
            rsp_in.eviction_total = evict_ff;
            rsp_in.occupancy = live_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         pend_ff <= 1'b0;
         valid_ff <= '0;
         live_ff <= '0;
         hits_ff <= '0;
         miss_ff <= '0;
         evict_ff <= '0;
         max_ff <= kvc_pkg::CFG_BITS'(kvc_pkg::CAPACITY);
         policy_ff <= kvc_pkg::POLICY_LRU;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         pend_ff <= pend_in;
         valid_ff <= valid_in;
         live_ff <= live_in;
         hits_ff <= hits_in;
         miss_ff <= miss_in;
         evict_ff <= evict_in;
         max_ff <= max_in;
         policy_ff <= policy_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff <= req_in;      pidx_ff <= pidx_in;   found_ff <= found_in;
      fslot_ff <= fslot_in;  fent_ff <= fent_in;   vic_ff <= vic_in;
      vslot_ff <= vslot_in;  vent_ff <= vent_in;   free_ff <= free_in;
      fidx_ff <= fidx_in;    rop_ff <= rop_in;     rref_ff <= rref_in;
      twr_ff <= twr_in;      tgt_ff <= tgt_in;     tent_ff <= tent_in;
      again_ff <= again_in;  status_ff <= status_in;
      vout_ff <= vout_in;    present_ff <= present_in;
      rsp_ff <= rsp_in;
   end

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the key-value cache with LRU/LFU eviction and TTL.
// A directed table covers misses, time wrap, lifetime edges, expired rewrites,
// unused opcodes and clear; random traffic over a small key pool then runs
// through several capacity and policy settings. Each result is checked against
// a fixed word of the table or a cycle-free model of the store in the bench.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;

   localparam logic POLICY_LFU = 1'b1;
   localparam int   LIMIT      = 600000;
   localparam int   N_PHASES   = 8;
   localparam int   PHASE_ITEMS = 138;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   kvc_pkg::req_type req_data = '0;
   logic rsp_strobe;
   kvc_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [kvc_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [kvc_pkg::CFG_BITS-1:0] csr_data = '0;

   always #2 clock = ~clock;

   kv_cache_lru_lfu_ttl i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // mirror of the store
   bit              m_valid[kvc_pkg::CAPACITY];
   logic [31:0]     m_key[kvc_pkg::CAPACITY];
   logic [31:0]     m_value[kvc_pkg::CAPACITY];
   logic [31:0]     m_stamp[kvc_pkg::CAPACITY];
   logic [31:0]     m_life[kvc_pkg::CAPACITY];
   logic [31:0]     m_uses[kvc_pkg::CAPACITY];
   int              m_rank[kvc_pkg::CAPACITY];
   int              m_count = 0;
   logic [31:0]     m_hits = '0, m_misses = '0, m_evicts = '0;
   logic [4:0]      m_max = 5'd16;
   logic            m_policy = kvc_pkg::POLICY_LRU;

   kvc_pkg::rsp_type expected_rsp_q[$];
   int      errors = 0;
   int      cycles = 0;

   function automatic int slot_of_key(logic [31:0] k);
      for (int i = 0; i < kvc_pkg::CAPACITY; i++)
         if (m_valid[i] && m_key[i] == k) return i;
      return -1;
   endfunction

   function automatic bit expired_at(int s, logic [31:0] now);
      logic [31:0] age;
      age = now - m_stamp[s];
      return m_life[s] != 0 && age > m_life[s];
   endfunction

   function automatic void promote_slot(int s);
      int r;
      r = m_rank[s];
      for (int i = 0; i < kvc_pkg::CAPACITY; i++)
         if (m_valid[i] && i != s && m_rank[i] < r) m_rank[i]++;
      m_rank[s] = 0;
   endfunction

   function automatic void free_slot(int s);
      int r;
      r = m_rank[s];
      m_valid[s] = 0;
      for (int i = 0; i < kvc_pkg::CAPACITY; i++)
         if (m_valid[i] && m_rank[i] > r) m_rank[i]--;
      if (m_count > 0) m_count--;
   endfunction

   function automatic int choose_victim();
      int v;
      v = -1;
      for (int i = 0; i < kvc_pkg::CAPACITY; i++) begin
         if (!m_valid[i]) continue;
         if (v < 0) v = i;
         else if (m_policy == kvc_pkg::POLICY_LRU) begin
            if (m_rank[i] > m_rank[v]) v = i;
         end else if (m_uses[i] < m_uses[v] ||
                      (m_uses[i] == m_uses[v] && m_rank[i] < m_rank[v])) begin
            v = i;
         end
      end
      return v;
   endfunction

   function automatic void store_put(kvc_pkg::req_type q);
      int s, cap, v;
      bit dead;
      s = slot_of_key(q.key);
      if (s >= 0) begin
         dead = expired_at(s, q.now_ms);
         m_value[s] = q.value_in;
         m_stamp[s] = q.now_ms;
         m_life[s] = q.ttl;
         if (dead) begin
            m_uses[s] = 0;
            promote_slot(s);
         end else if (m_policy == kvc_pkg::POLICY_LRU) begin
            promote_slot(s);
         end
         return;
      end
      cap = (m_max == 0) ? 1 : (m_max > kvc_pkg::CAPACITY ? kvc_pkg::CAPACITY : m_max);
      while (m_count >= cap && m_count > 0) begin
         v = choose_victim();
         if (v < 0) break;
         free_slot(v);
         m_evicts++;
      end
      for (int i = 0; i < kvc_pkg::CAPACITY; i++)
         if (!m_valid[i]) begin
            s = i;
            break;
         end
      if (s < 0) return;
      for (int i = 0; i < kvc_pkg::CAPACITY; i++)
         if (m_valid[i]) m_rank[i]++;
      m_valid[s] = 1;
      m_key[s] = q.key;
      m_value[s] = q.value_in;
      m_stamp[s] = q.now_ms;
      m_life[s] = q.ttl;
      m_uses[s] = 0;
      m_rank[s] = 0;
      m_count++;
   endfunction

   function automatic kvc_pkg::rsp_type cache_step(kvc_pkg::req_type q);
      kvc_pkg::rsp_type r;
      int s;
      r = '0;
      case (q.opcode)
         kvc_pkg::OP_PUT: store_put(q);
         kvc_pkg::OP_GET, kvc_pkg::OP_DELETE, kvc_pkg::OP_EXISTS: begin
            s = slot_of_key(q.key);
            if (s >= 0 && expired_at(s, q.now_ms)) s = -1;
            if (q.opcode == kvc_pkg::OP_GET) begin
               if (s >= 0) begin
                  m_hits++;
                  m_uses[s]++;
                  if (m_policy == kvc_pkg::POLICY_LRU) promote_slot(s);
                  r.value_out = m_value[s];
               end else begin
                  m_misses++;
                  r.status = 1'b1;
               end
            end else if (q.opcode == kvc_pkg::OP_DELETE) begin
               if (s >= 0) free_slot(s);
               else r.status = 1'b1;
            end else begin
               if (s >= 0) r.present = 1'b1;
               else r.status = 1'b1;
            end
         end
         kvc_pkg::OP_CLEAR: begin
            for (int i = 0; i < kvc_pkg::CAPACITY; i++) m_valid[i] = 0;
            m_count = 0;
         end
         default: ;
      endcase
      r.hit_total = m_hits;
      r.miss_total = m_misses;
      r.eviction_total = m_evicts;
      r.occupancy = m_count[kvc_pkg::CNT_BITS-1:0];
      return r;
   endfunction

   function automatic kvc_pkg::req_type mk_req(logic [2:0] op, logic [31:0] k,
                                               logic [31:0] v, logic [31:0] t,
                                               logic [31:0] now);
      kvc_pkg::req_type q;
      q.opcode = op;
      q.key = k;
      q.value_in = v;
      q.ttl = t;
      q.now_ms = now;
      return q;
   endfunction

   function automatic kvc_pkg::rsp_type mk_rsp(logic st, logic [31:0] v, logic pr,
                                               logic [31:0] h, logic [31:0] m,
                                               logic [31:0] e, int occ);
      kvc_pkg::rsp_type r;
      r.status = st;
      r.value_out = v;
      r.present = pr;
      r.hit_total = h;
      r.miss_total = m;
      r.eviction_total = e;
      r.occupancy = occ[kvc_pkg::CNT_BITS-1:0];
      return r;
   endfunction

   // send one word; the caller is at a rising edge
   task automatic send_word(kvc_pkg::req_type q, int gap, bit fixed,
                            kvc_pkg::rsp_type fixed_rsp);
      kvc_pkg::rsp_type p;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (busy);
      p = cache_step(q);
      expected_rsp_q.push_back(fixed ? fixed_rsp : p);
   endtask

   task automatic write_csr(logic [kvc_pkg::CSR_IDX_BITS-1:0] idx,
                            logic [kvc_pkg::CFG_BITS-1:0] d);
      start <= 1'b0;
      do @(posedge clock); while (expected_rsp_q.size() != 0 || busy);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == kvc_pkg::CSR_MAX_ENTRIES) m_max = d;
      else m_policy = d[0];
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %h", rsp_data);
         end else begin
            kvc_pkg::rsp_type e;
            e = expected_rsp_q.pop_front();
            if (rsp_data !== e) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: st %b/%b val %h/%h pres %b/%b hit %0d/%0d ",
                            "miss %0d/%0d evict %0d/%0d occ %0d/%0d (exp/got)"},
                           e.status, rsp_data.status, e.value_out, rsp_data.value_out,
                           e.present, rsp_data.present, e.hit_total, rsp_data.hit_total,
                           e.miss_total, rsp_data.miss_total, e.eviction_total,
                           rsp_data.eviction_total, e.occupancy, rsp_data.occupancy);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      kvc_pkg::req_type dir_req[$];
      bit               dir_fixed[$];
      kvc_pkg::rsp_type dir_rsp[$];
      logic [31:0]      pool[24];
      logic [31:0]      now_t;
      logic [4:0]       caps[N_PHASES];
      logic             pols[N_PHASES];
      kvc_pkg::req_type q;
      int               r, gap;
      bit               quiet;

      caps = '{5'd16, 5'd1, 5'd0, 5'd3, 5'd31, 5'd5, 5'd16, 5'd2};
      pols = '{kvc_pkg::POLICY_LRU, POLICY_LFU, kvc_pkg::POLICY_LRU, POLICY_LFU,
               POLICY_LFU, kvc_pkg::POLICY_LRU, POLICY_LFU, kvc_pkg::POLICY_LRU};

      // misses on an empty store
      dir_req.push_back(mk_req(kvc_pkg::OP_GET, 32'h0, 32'h0, 32'h0, 32'h0));
      dir_fixed.push_back(1); dir_rsp.push_back(mk_rsp(1, 0, 0, 0, 1, 0, 0));
      dir_req.push_back(mk_req(kvc_pkg::OP_EXISTS, '1, '1, '1, '1));
      dir_fixed.push_back(1); dir_rsp.push_back(mk_rsp(1, 0, 0, 0, 1, 0, 0));
      dir_req.push_back(mk_req(kvc_pkg::OP_DELETE, 32'h5, 32'h0, 32'h0, 32'h0));
      dir_fixed.push_back(1); dir_rsp.push_back(mk_rsp(1, 0, 0, 0, 1, 0, 0));
      // extremes of key and value, no lifetime
      dir_req.push_back(mk_req(kvc_pkg::OP_PUT, 32'h0, '1, 32'h0, 32'h0));
      dir_fixed.push_back(1); dir_rsp.push_back(mk_rsp(0, 0, 0, 0, 1, 0, 1));
      dir_req.push_back(mk_req(kvc_pkg::OP_GET, 32'h0, 32'h0, 32'h0, '1));
      dir_fixed.push_back(1); dir_rsp.push_back(mk_rsp(0, '1, 0, 1, 1, 0, 1));
      // lifetime across the time wrap: expired at age 21, live at age 10
      dir_req.push_back(mk_req(kvc_pkg::OP_PUT, '1, 32'h0, 32'd10, 32'hFFFF_FFF0));
      dir_fixed.push_back(1); dir_rsp.push_back(mk_rsp(0, 0, 0, 1, 1, 0, 2));
      dir_req.push_back(mk_req(kvc_pkg::OP_EXISTS, '1, 32'h0, 32'h0, 32'd5));
      dir_fixed.push_back(1); dir_rsp.push_back(mk_rsp(1, 0, 0, 1, 1, 0, 2));
      dir_req.push_back(mk_req(kvc_pkg::OP_EXISTS, '1, 32'h0, 32'h0, 32'hFFFF_FFFA));
      dir_fixed.push_back(1); dir_rsp.push_back(mk_rsp(0, 0, 1, 1, 1, 0, 2));
      // rewrite of an expired key reuses its slot
      dir_req.push_back(mk_req(kvc_pkg::OP_PUT, '1, 32'd7, '1, 32'd100));
      dir_fixed.push_back(1); dir_rsp.push_back(mk_rsp(0, 0, 0, 1, 1, 0, 2));
      dir_req.push_back(mk_req(kvc_pkg::OP_GET, '1, 32'h0, 32'h0, 32'd50));
      dir_fixed.push_back(1); dir_rsp.push_back(mk_rsp(0, 32'd7, 0, 2, 1, 0, 2));
      dir_req.push_back(mk_req(kvc_pkg::OP_DELETE, '1, 32'h0, 32'h0, 32'd60));
      dir_fixed.push_back(1); dir_rsp.push_back(mk_rsp(0, 0, 0, 2, 1, 0, 1));
      // unused opcodes do nothing
      dir_req.push_back(mk_req(3'd5, 32'h0, 32'h0, 32'h0, 32'd60));
      dir_fixed.push_back(1); dir_rsp.push_back(mk_rsp(0, 0, 0, 2, 1, 0, 1));
      dir_req.push_back(mk_req(3'd7, '1, '1, '1, '1));
      dir_fixed.push_back(1); dir_rsp.push_back(mk_rsp(0, 0, 0, 2, 1, 0, 1));
      dir_req.push_back(mk_req(kvc_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0, 32'd70));
      dir_fixed.push_back(1); dir_rsp.push_back(mk_rsp(0, 0, 0, 2, 1, 0, 0));
      // a few live puts and gets, checked by the mirror
      for (int i = 0; i < 6; i++) begin
         dir_req.push_back(mk_req(kvc_pkg::OP_PUT, 32'd10 + i % 3, $urandom, 32'd0,
                                  32'd80 + i));
         dir_fixed.push_back(0); dir_rsp.push_back('0);
         dir_req.push_back(mk_req(kvc_pkg::OP_GET, 32'd10 + i % 4, 32'h0, 32'h0,
                                  32'd90 + i));
         dir_fixed.push_back(0); dir_rsp.push_back('0);
      end

      pool[0] = '0;
      pool[1] = '1;
      for (int i = 2; i < 24; i++) pool[i] = $urandom;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_csr(kvc_pkg::CSR_MAX_ENTRIES, 5'd16);
      write_csr(kvc_pkg::CSR_POLICY, {4'b0, kvc_pkg::POLICY_LRU});

      foreach (dir_req[i])
         send_word(dir_req[i], $urandom_range(0, 3), dir_fixed[i], dir_rsp[i]);

      // start close to the top so the clock wraps during the run
      now_t = 32'hFFFF_F000;
      quiet = 0;
      for (int ph = 0; ph < N_PHASES; ph++) begin
         write_csr(kvc_pkg::CSR_MAX_ENTRIES, caps[ph]);
         write_csr(kvc_pkg::CSR_POLICY, {4'b0, pols[ph]});
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 24) == 0) quiet = ~quiet;
            r = $urandom_range(0, 99);
            q.opcode = r < 35 ? kvc_pkg::OP_PUT : r < 65 ? kvc_pkg::OP_GET :
                       r < 75 ? kvc_pkg::OP_DELETE : r < 90 ? kvc_pkg::OP_EXISTS :
                       r < 93 ? kvc_pkg::OP_CLEAR : 3'($urandom_range(5, 7));
            q.key = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 23)];
            q.value_in = $urandom;
            r = $urandom_range(0, 9);
            q.ttl = r < 3 ? 32'd0 : r < 8 ? 32'($urandom_range(1, 60)) : $urandom;
            now_t = now_t + $urandom_range(0, 15);
            if ($urandom_range(0, 49) == 0) now_t = now_t + $urandom;
            q.now_ms = now_t;
            gap = quiet ? 0 : $urandom_range(0, 9);
            send_word(q, gap, 0, '0);
         end
      end

      start <= 1'b0;
      do @(posedge clock); while (expected_rsp_q.size() != 0);
      repeat (60) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
`default_nettype wire

@@ sim.f @@
src/kvc_pkg.sv
src/kvc_ram.sv
src/kv_cache_lru_lfu_ttl.sv
tb/tb.sv
